// File: hdl/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types, constants and helpers of the color palette RAM block.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int unsigned PALETTE_BYTES = 64;
  localparam int unsigned IDX_W         = $clog2(PALETTE_BYTES);

  localparam logic [15:0] ADDR_BG_SPEC = 16'hFF68;
  localparam logic [15:0] ADDR_BG_DATA = 16'hFF69;
  localparam logic [15:0] ADDR_SP_SPEC = 16'hFF6A;
  localparam logic [15:0] ADDR_SP_DATA = 16'hFF6B;
  localparam logic [7:0]  INVALID_READ = 8'hFF;
  localparam int unsigned AUTO_INC_BIT = 7;

  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_WRITE     = 2'd1,
    OP_BG_LOOKUP = 2'd2,
    OP_SP_LOOKUP = 2'd3
  } cpr_op_t;

  typedef struct packed {
    logic acc_read;
    logic acc_write;
    logic acc_lookup;
    logic load_color;
  } cpr_ctl_t;

  function automatic logic [7:0] widen5(input logic [4:0] c);
    widen5 = {c, c[4:2]};
  endfunction

endpackage

// File: hdl/cpr_req_if.sv
// ----------------------------------------------------------------------------
// cpr_req_if
// Request channel: bus access or color lookup word.
// ----------------------------------------------------------------------------
interface cpr_req_if #(
  parameter int unsigned IDX_W = cpr_pkg::IDX_W
);
  logic             valid;
  logic             ready;
  cpr_pkg::cpr_op_t cmd;
  logic [15:0]      address;
  logic [7:0]       write_data;
  logic [IDX_W-1:0] color_index;

  modport source (output valid, cmd, address, write_data, color_index, input ready);
  modport sink   (input valid, cmd, address, write_data, color_index, output ready);
endinterface

// File: hdl/cpr_rsp_if.sv
// ----------------------------------------------------------------------------
// cpr_rsp_if
// Response channel: read byte or widened color word.
// ----------------------------------------------------------------------------
interface cpr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, read_data, red, green, blue, input ready);
  modport sink   (input valid, read_data, red, green, blue, output ready);
endinterface

// File: hdl/cpr_ram.sv
// ----------------------------------------------------------------------------
// cpr_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module cpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = cpr_pkg::PALETTE_BYTES
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// File: hdl/cpr_ctrl.sv
// ----------------------------------------------------------------------------
// cpr_ctrl
// Controller: accepts words, sequences lookups, owns the result valid.
// ----------------------------------------------------------------------------
module cpr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  cpr_pkg::cpr_op_t  req_cmd,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output cpr_pkg::cpr_ctl_t ctl
);

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_t;

  state_t state;
  logic   accept;

  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;

  always_comb begin
    ctl            = '0;
    ctl.acc_read   = accept && (req_cmd == cpr_pkg::OP_READ);
    ctl.acc_write  = accept && (req_cmd == cpr_pkg::OP_WRITE);
    ctl.acc_lookup = accept && ((req_cmd == cpr_pkg::OP_BG_LOOKUP) ||
                                (req_cmd == cpr_pkg::OP_SP_LOOKUP));
    ctl.load_color = (state == S_LOOKUP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.acc_lookup) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (ctl.acc_read || ctl.load_color) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_lookup_blocks: assert property (@(posedge clk) disable iff (rst)
    ctl.acc_lookup |=> !req_ready)
    else $error("word accepted during lookup");

  a_lookup_result: assert property (@(posedge clk) disable iff (rst)
    ctl.acc_lookup |=> ##1 rsp_valid)
    else $error("lookup result missing");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    ctl.acc_read |=> rsp_valid)
    else $error("read result missing");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (ctl.acc_write && !rsp_valid) |=> !rsp_valid)
    else $error("write produced a result");

endmodule

// File: hdl/cpr_datapath.sv
// ----------------------------------------------------------------------------
// cpr_datapath
// Datapath: spec and data registers, palette RAMs, result register.
// ----------------------------------------------------------------------------
module cpr_datapath #(
  parameter int unsigned PALETTE_BYTES = cpr_pkg::PALETTE_BYTES,
  parameter int unsigned IDX_W         = $clog2(PALETTE_BYTES)
) (
  input  logic              clk,
  input  logic              rst,
  input  cpr_pkg::cpr_ctl_t ctl,
  input  cpr_pkg::cpr_op_t  cmd,
  input  logic [15:0]       address,
  input  logic [7:0]        write_data,
  input  logic [IDX_W-1:0]  color_index,
  output logic [7:0]        read_data,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue
);

  logic [7:0]       bg_spec;
  logic [7:0]       bg_latch;
  logic [7:0]       sp_spec;
  logic [7:0]       sp_latch;
  logic             sel_sprite;
  logic             bg_wr;
  logic             sp_wr;
  logic [IDX_W-1:0] hi_index;
  logic [7:0]       bg_lo;
  logic [7:0]       bg_hi;
  logic [7:0]       sp_lo;
  logic [7:0]       sp_hi;
  logic [15:0]      color;
  logic [7:0]       reg_byte;

  assign bg_wr    = ctl.acc_write && (address == cpr_pkg::ADDR_BG_DATA);
  assign sp_wr    = ctl.acc_write && (address == cpr_pkg::ADDR_SP_DATA);
  assign hi_index = color_index + IDX_W'(1);

  cpr_ram #(.WIDTH(8), .DEPTH(PALETTE_BYTES)) u_bg_ram (
    .clk       (clk),
    .wr_en     (bg_wr),
    .wr_addr   (bg_spec[IDX_W-1:0]),
    .wr_data   (write_data),
    .rd_en     (ctl.acc_lookup),
    .rd_addr_a (color_index),
    .rd_addr_b (hi_index),
    .rd_data_a (bg_lo),
    .rd_data_b (bg_hi)
  );

  cpr_ram #(.WIDTH(8), .DEPTH(PALETTE_BYTES)) u_sp_ram (
    .clk       (clk),
    .wr_en     (sp_wr),
    .wr_addr   (sp_spec[IDX_W-1:0]),
    .wr_data   (write_data),
    .rd_en     (ctl.acc_lookup),
    .rd_addr_a (color_index),
    .rd_addr_b (hi_index),
    .rd_data_a (sp_lo),
    .rd_data_b (sp_hi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_spec  <= '0;
      bg_latch <= '0;
      sp_spec  <= '0;
      sp_latch <= '0;
    end else if (ctl.acc_write) begin
      unique case (address)
        cpr_pkg::ADDR_BG_SPEC: bg_spec <= write_data;
        cpr_pkg::ADDR_BG_DATA: begin
          bg_latch <= write_data;
          if (bg_spec[cpr_pkg::AUTO_INC_BIT]) begin
            bg_spec[IDX_W-1:0] <= bg_spec[IDX_W-1:0] + IDX_W'(1);
          end
        end
        cpr_pkg::ADDR_SP_SPEC: sp_spec <= write_data;
        cpr_pkg::ADDR_SP_DATA: begin
          sp_latch <= write_data;
          if (sp_spec[cpr_pkg::AUTO_INC_BIT]) begin
            sp_spec[IDX_W-1:0] <= sp_spec[IDX_W-1:0] + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (address)
      cpr_pkg::ADDR_BG_SPEC: reg_byte = bg_spec;
      cpr_pkg::ADDR_BG_DATA: reg_byte = bg_latch;
      cpr_pkg::ADDR_SP_SPEC: reg_byte = sp_spec;
      cpr_pkg::ADDR_SP_DATA: reg_byte = sp_latch;
      default:               reg_byte = cpr_pkg::INVALID_READ;
    endcase
  end

  assign color = sel_sprite ? {sp_hi, sp_lo} : {bg_hi, bg_lo};

  always_ff @(posedge clk) begin
    if (ctl.acc_lookup) begin
      sel_sprite <= (cmd == cpr_pkg::OP_SP_LOOKUP);
    end
    if (ctl.acc_read) begin
      read_data <= reg_byte;
      red       <= '0;
      green     <= '0;
      blue      <= '0;
    end else if (ctl.load_color) begin
      read_data <= '0;
      red       <= cpr_pkg::widen5(color[4:0]);
      green     <= cpr_pkg::widen5(color[9:5]);
      blue      <= cpr_pkg::widen5(color[14:10]);
    end
  end

endmodule

// File: hdl/color_palette_ram_with_autoincrement_core.sv
// ----------------------------------------------------------------------------
// color_palette_ram_with_autoincrement_core
// Background and sprite palette RAMs behind spec/data bus registers.
// ----------------------------------------------------------------------------
// A bus read answers from the output register; a write gives no response word.
// A color lookup passes through the registered read of the palette RAM,
// which fetches both bytes of the entry in one access, and then the output
// register; no request is taken in its lookup state. The response sits in an
// output register, and a new request is taken only while that register is
// empty or its word is taken in the same cycle.
module color_palette_ram_with_autoincrement_core #(
  parameter int unsigned PALETTE_BYTES = cpr_pkg::PALETTE_BYTES
) (
  input logic      clk,
  input logic      rst,
  cpr_req_if.sink  req,
  cpr_rsp_if.source rsp
);

  cpr_pkg::cpr_ctl_t ctl;

  cpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctl       (ctl)
  );

  cpr_datapath #(.PALETTE_BYTES(PALETTE_BYTES)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cmd         (req.cmd),
    .address     (req.address),
    .write_data  (req.write_data),
    .color_index (req.color_index),
    .read_data   (rsp.read_data),
    .red         (rsp.red),
    .green       (rsp.green),
    .blue        (rsp.blue)
  );

endmodule
